// ===== hw/rtl/yt_pkg.sv =====
// ----------------------------------------------------------------------------
// yt_pkg
// shared types for the young tableau row insertion block
// ----------------------------------------------------------------------------
package yt_pkg;

  typedef struct packed {
    logic               start_new;
    logic signed [15:0] element;
  } in_t;

  typedef struct packed {
    logic [5:0] new_row;
    logic [5:0] new_column;
    logic [6:0] insert_number;
    logic       overflow;
  } out_t;

  typedef struct packed {
    logic load;
    logic len_cap;
    logic scan;
    logic dec;
    logic bump;
    logic fin;
    logic ovf;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic c_zero;
    logic cmp_ge;
    logic c_eq_len;
    logic c_at_max;
    logic r_last;
    logic slot_free;
  } sts_t;

endpackage

// ===== hw/rtl/yt_ram.sv =====
// ----------------------------------------------------------------------------
// yt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module yt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/yt_ctrl.sv =====
// ----------------------------------------------------------------------------
// yt_ctrl
// sequencer for row walk, column scan and bump of one insertion
// ----------------------------------------------------------------------------
module yt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  yt_pkg::sts_t  sts_i,
  output yt_pkg::cmd_t  cmd_o
);
  import yt_pkg::*;

  typedef enum logic [2:0] {
    IDLE, ROWRD, LENCAP, SCAN, CMP, DECIDE, BUMPRD, BUMP
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   ovf_q, ovf_d;

  assign in_stall_o = (state_q != IDLE) || fin_q || ovf_q;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    ovf_d   = ovf_q;
    cmd_o   = '0;
    if (fin_q) begin
      cmd_o.fin = sts_i.slot_free;
      if (sts_i.slot_free) fin_d = 1'b0;
    end else if (ovf_q) begin
      cmd_o.ovf = sts_i.slot_free;
      if (sts_i.slot_free) ovf_d = 1'b0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            if (sts_i.full) ovf_d = 1'b1;
            else state_d = ROWRD;
          end
        end
        ROWRD: state_d = LENCAP;
        LENCAP: begin
          cmd_o.len_cap = 1'b1;
          state_d = SCAN;
        end
        SCAN: begin
          if (sts_i.c_zero) begin
            state_d = DECIDE;
          end else begin
            cmd_o.scan = 1'b1;
            state_d = CMP;
          end
        end
        CMP: begin
          if (sts_i.cmp_ge) begin
            cmd_o.dec = 1'b1;
            state_d = SCAN;
          end else begin
            state_d = DECIDE;
          end
        end
        DECIDE: begin
          if (sts_i.c_eq_len) begin
            state_d = IDLE;
            if (sts_i.c_at_max) ovf_d = 1'b1;
            else fin_d = 1'b1;
          end else begin
            state_d = BUMPRD;
          end
        end
        BUMPRD: state_d = BUMP;
        BUMP: begin
          cmd_o.bump = 1'b1;
          if (sts_i.r_last) begin
            state_d = IDLE;
            ovf_d = 1'b1;
          end else begin
            state_d = ROWRD;
          end
        end
        default: state_d = IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      fin_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== hw/rtl/yt_dp.sv =====
// ----------------------------------------------------------------------------
// yt_dp
// datapath: tableau ram, row length ram, scan registers, result register
// ----------------------------------------------------------------------------
module yt_dp #(
  parameter int MAX_LEN    = 64,
  parameter int VALUE_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  yt_pkg::in_t   in_data_i,
  input  yt_pkg::cmd_t  cmd_i,
  output yt_pkg::sts_t  sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output yt_pkg::out_t  out_data_o
);
  import yt_pkg::*;

  localparam int RB = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [31:0] Limit = 32'((64'd1 << VALUE_BITS) - 64'd1);

  logic [VALUE_BITS-1:0] v_q;
  logic [RB-1:0]         r_q;
  logic [CW-1:0]         c_q, cmax_q, len_q, count_q, num_q;
  logic [MAX_LEN-1:0]    valid_q;
  logic                  out_valid_q;
  out_t                  out_q;

  logic [15:0]           raw;
  logic [16:0]           mag;
  logic [31:0]           mag_w;
  logic [VALUE_BITS-1:0] v_in;
  logic [CW-1:0]         count_eff, len_eff, cmax_new, c_m1;
  logic [VALUE_BITS-1:0] cell_rdata;
  logic [CW-1:0]         len_rdata;
  logic                  cell_we;
  logic [2*RB-1:0]       cell_raddr, cell_waddr;
  logic                  slot_free;

  assign raw   = in_data_i.element;
  assign mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
  assign mag_w = 32'(mag);
  assign v_in  = (mag_w > Limit) ? VALUE_BITS'(Limit) : VALUE_BITS'(mag_w);

  assign count_eff = in_data_i.start_new ? '0 : count_q;
  assign len_eff   = valid_q[r_q] ? len_rdata : '0;
  assign cmax_new  = (len_eff < cmax_q) ? len_eff : cmax_q;
  assign c_m1      = c_q - CW'(1);

  assign cell_raddr = cmd_i.scan ? {r_q, c_m1[RB-1:0]} : {r_q, c_q[RB-1:0]};
  assign cell_waddr = {r_q, c_q[RB-1:0]};
  assign cell_we    = cmd_i.bump || cmd_i.fin;

  yt_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << (2 * RB))) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (v_q),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  yt_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_lens (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fin),
    .waddr_i (r_q),
    .wdata_i (len_q + CW'(1)),
    .raddr_i (r_q),
    .rdata_o (len_rdata)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  assign sts_o.full      = (32'(count_eff) >= 32'(MAX_LEN));
  assign sts_o.c_zero    = (c_q == '0);
  assign sts_o.cmp_ge    = (cell_rdata >= v_q);
  assign sts_o.c_eq_len  = (c_q == len_q);
  assign sts_o.c_at_max  = (32'(c_q) >= 32'(MAX_LEN));
  assign sts_o.r_last    = (r_q == RB'(MAX_LEN - 1));
  assign sts_o.slot_free = slot_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= v_in;
      r_q    <= '0;
      cmax_q <= CW'(MAX_LEN);
      num_q  <= count_eff + CW'(1);
    end
    if (cmd_i.len_cap) begin
      len_q  <= len_eff;
      cmax_q <= cmax_new;
      c_q    <= cmax_new;
    end
    if (cmd_i.dec) c_q <= c_m1;
    if (cmd_i.bump) begin
      v_q    <= cell_rdata;
      cmax_q <= c_q;
      r_q    <= r_q + RB'(1);
    end
    if (cmd_i.fin) begin
      out_q.new_row       <= 6'(r_q);
      out_q.new_column    <= 6'(c_q);
      out_q.insert_number <= 7'(num_q);
      out_q.overflow      <= 1'b0;
    end
    if (cmd_i.ovf) out_q <= '{default: '0, overflow: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_data_i.start_new) begin
        valid_q <= '0;
        count_q <= '0;
      end
      if (cmd_i.fin) begin
        valid_q[r_q] <= 1'b1;
        count_q      <= num_q;
      end
      if (cmd_i.fin || cmd_i.ovf) out_valid_q <= 1'b1;
      else if (!out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/young_tableau_row_insertion.sv =====
// ----------------------------------------------------------------------------
// young_tableau_row_insertion
// one transaction at a time; after acceptance each row visited reads its row
// length (ROWRD, LENCAP), compares cells leftward (SCAN, CMP), then decides
// (DECIDE) and, for a bump, swaps the cell (BUMPRD, BUMP) into the next row;
// the result register loads after the final DECIDE or BUMP, later while the
// output is stalled, and the next transaction is taken once it has loaded
// reset empties the tableau at once through row valid bits, no clearing pass
// ----------------------------------------------------------------------------
module young_tableau_row_insertion #(
  parameter int MAX_LEN    = 64,
  parameter int VALUE_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  yt_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output yt_pkg::out_t  out_data_o
);
  import yt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  yt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  yt_dp #(.MAX_LEN(MAX_LEN), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks young_tableau_row_insertion: random and directed insertions are fed
// in, each accepted transaction updates a local copy of the tableau, and
// every result is compared field by field with the oldest predicted cell
// ----------------------------------------------------------------------------
module tb_top;
  import yt_pkg::*;

  localparam int MaxLen = 64;
  localparam int ValueBits = 15;

  class cell_scoreboard;
    int unsigned cells[MaxLen][MaxLen];
    int unsigned row_len[MaxLen];
    int unsigned count;
    out_t cell_q[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
      foreach (row_len[i]) row_len[i] = 0;
    endfunction

    function void note_insert(in_t item);
      int unsigned v, mag, cmax, c, len, bumped, r, num;
      logic [15:0] bits;
      out_t res;
      res = '0;
      if (item.start_new) begin
        foreach (row_len[i]) row_len[i] = 0;
        count = 0;
      end
      bits = item.element;
      if (bits[15]) mag = (32'h10000 - bits) & 32'h1ffff;
      else mag = bits;
      v = (mag > (2 ** ValueBits - 1)) ? (2 ** ValueBits - 1) : mag;
      if (count >= MaxLen) begin
        res.overflow = 1'b1;
        cell_q.push_back(res);
        return;
      end
      num = count + 1;
      cmax = row_len[0];
      res.overflow = 1'b1;
      for (r = 0; r < MaxLen; r++) begin
        len = row_len[r];
        if (len < cmax) cmax = len;
        c = cmax;
        while (c > 0 && cells[r][c-1] >= v) c--;
        if (c == len) begin
          if (c >= MaxLen) break;
          cells[r][c] = v;
          row_len[r] = len + 1;
          count = num;
          res.new_row = r[5:0];
          res.new_column = c[5:0];
          res.insert_number = num[6:0];
          res.overflow = 1'b0;
          break;
        end else begin
          bumped = cells[r][c];
          cells[r][c] = v;
          v = bumped;
          cmax = c;
        end
      end
      cell_q.push_back(res);
    endfunction

    function void check_cell(out_t got);
      out_t want;
      if (cell_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, got);
        errors++;
        return;
      end
      want = cell_q.pop_front();
      if (got.new_row !== want.new_row)
        $display("%0t: new_row expected %0d actual %0d", $time, want.new_row, got.new_row);
      if (got.new_column !== want.new_column)
        $display("%0t: new_column expected %0d actual %0d", $time, want.new_column,
                 got.new_column);
      if (got.insert_number !== want.insert_number)
        $display("%0t: insert_number expected %0d actual %0d", $time, want.insert_number,
                 got.insert_number);
      if (got.overflow !== want.overflow)
        $display("%0t: overflow expected %0d actual %0d", $time, want.overflow, got.overflow);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  cell_scoreboard tableau_sb;

  always #4 clk_i = ~clk_i;

  young_tableau_row_insertion #(.MAX_LEN(MaxLen), .VALUE_BITS(ValueBits)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tableau_sb.check_cell(out_data_o);
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_element(bit start, logic signed [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{start_new: start, element: value};
    do @(posedge clk_i); while (in_stall_o);
    tableau_sb.note_insert(in_data_i);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    drop_valid();
    while (tableau_sb.cell_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_run(output int n);
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_element(i == 0, 16'($urandom_range(15)) - 16'sd8);
        1: send_element(i == 0, 16'($urandom_range(63)));
        default: send_element(i == 0 || $urandom_range(40) == 0, 16'($urandom()));
      endcase
    end
  endtask

  initial begin
    tableau_sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, equal values, saturation, descending to deepen rows
    send_element(1'b0, 16'sd5);
    send_element(1'b0, 16'sd5);
    send_element(1'b0, -16'sd32767);
    send_element(1'b0, 16'sh8000);
    send_element(1'b0, 16'sd0);
    send_element(1'b0, 16'sd32767);
    send_element(1'b0, -16'sd1);
    send_element(1'b1, 16'sd3);
    for (int i = 0; i < 10; i++) send_element(1'b0, 16'(10 - i));
    // fill to capacity and past it, then a start on a full tableau
    for (int i = 0; i < 70; i++) send_element(1'b0, 16'($urandom()));
    send_element(1'b1, 16'sd7);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 35 : 0;
      for (int k = 0; k < 600;) begin
        int sent;
        send_random_run(sent);
        k += sent;
        if ($urandom_range(15) == 0) drain();
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (tableau_sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
